[rtl/core/sbht_pkg.sv]
package sbht_pkg;

  // Width of every coordinate port and of the configuration data port.
  localparam int unsigned FIELD_WIDTH = 32;

  // Default number of low bits of each coordinate that take part in the test.
  localparam int unsigned COORD_WIDTH_DEF = 32;

  // Width of the configuration register index.
  localparam int unsigned CFG_INDEX_WIDTH = 4;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_MIN_X = CFG_INDEX_WIDTH'(0);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_MAX_X = CFG_INDEX_WIDTH'(1);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_MIN_Y = CFG_INDEX_WIDTH'(2);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOX_MAX_Y = CFG_INDEX_WIDTH'(3);

  // Cycles from an accepted item to its result strobe.
  localparam int unsigned PIPE_LATENCY = 4;

endpackage

[rtl/core/segment_box_hit_test.sv]
// Segment against box hit test.
//
// Each item on the command channel is one line segment (start_x_i, start_y_i,
// end_x_i, end_y_i). An item is accepted at a clock edge where start is high
// and busy is low; busy is always low, so one item can enter every cycle.
// The answer comes back as hit_o, qualified by valid_o for exactly one cycle,
// once the item has passed through every stage. Results leave in the order the
// items came in. The receiver has no way to hold results off and the pipeline
// never stalls, so the sustained rate is one item per clock; the depth is set
// by the four stages: differences, products, numerator terms, final compares.
//
// The box is held in four registers written over the configuration channel
// (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i). cfg_ready_o is always
// high; indexes beyond the box registers are ignored. Write the box only while
// no items are in flight. Reset clears the box to all zeros and drops every
// item still in the pipeline; no result strobe is produced for those.
module segment_box_hit_test #(
  parameter int unsigned COORD_WIDTH = sbht_pkg::COORD_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Command channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic [sbht_pkg::FIELD_WIDTH-1:0]     start_x_i,
  input  logic [sbht_pkg::FIELD_WIDTH-1:0]     start_y_i,
  input  logic [sbht_pkg::FIELD_WIDTH-1:0]     end_x_i,
  input  logic [sbht_pkg::FIELD_WIDTH-1:0]     end_y_i,
  // Result
  output logic                                 valid_o,
  output logic                                 hit_o,
  // Configuration channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [sbht_pkg::CFG_INDEX_WIDTH-1:0] cfg_index_i,
  input  logic [sbht_pkg::FIELD_WIDTH-1:0]     cfg_data_i
);
  import sbht_pkg::*;

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned DW = CW + 1;  // coordinate differences
  localparam int unsigned PW = 2 * DW;  // exact products
  localparam int unsigned NW = PW + 1;  // difference of two products

  // True when 0 <= n/d <= 1 for a nonzero d, computed without division.
  function automatic logic unit_ratio(logic signed [NW-1:0] n, logic signed [NW-1:0] d);
    logic d_pos;
    logic d_neg;
    logic n_nonneg;
    logic n_nonpos;
    d_pos    = !d[NW-1] && (d != '0);
    d_neg    = d[NW-1];
    n_nonneg = !n[NW-1];
    n_nonpos = n[NW-1] || (n == '0);
    return (d_pos && n_nonneg && (n <= d)) || (d_neg && n_nonpos && (n >= d));
  endfunction

  // The block never stalls.
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Box registers.
  logic signed [CW-1:0] box_min_x_q, box_max_x_q, box_min_y_q, box_max_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_min_x_q <= '0;
      box_max_x_q <= '0;
      box_min_y_q <= '0;
      box_max_y_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_BOX_MIN_X: box_min_x_q <= cfg_data_i[CW-1:0];
        REG_BOX_MAX_X: box_max_x_q <= cfg_data_i[CW-1:0];
        REG_BOX_MIN_Y: box_min_y_q <= cfg_data_i[CW-1:0];
        REG_BOX_MAX_Y: box_max_y_q <= cfg_data_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: endpoint containment and all coordinate differences.
  logic signed [CW-1:0] sx, sy, ex, ey;
  logic                 inside_d;
  logic signed [DW-1:0] dxs_d, dys_d, qx0_d, qx1_d, qy0_d, qy1_d, w_d, h_d;

  assign sx = start_x_i[CW-1:0];
  assign sy = start_y_i[CW-1:0];
  assign ex = end_x_i[CW-1:0];
  assign ey = end_y_i[CW-1:0];

  always_comb begin
    inside_d = (sx >= box_min_x_q && sx <= box_max_x_q &&
                sy >= box_min_y_q && sy <= box_max_y_q) ||
               (ex >= box_min_x_q && ex <= box_max_x_q &&
                ey >= box_min_y_q && ey <= box_max_y_q);
    dxs_d = DW'(ex) - DW'(sx);
    dys_d = DW'(ey) - DW'(sy);
    qx0_d = DW'(box_min_x_q) - DW'(sx);
    qx1_d = DW'(box_max_x_q) - DW'(sx);
    qy0_d = DW'(box_min_y_q) - DW'(sy);
    qy1_d = DW'(box_max_y_q) - DW'(sy);
    w_d   = DW'(box_max_x_q) - DW'(box_min_x_q);
    h_d   = DW'(box_max_y_q) - DW'(box_min_y_q);
  end

  logic                 v1_q, in1_q;
  logic signed [DW-1:0] dxs_q, dys_q, qx0_q, qx1_q, qy0_q, qy1_q, w_q, h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    in1_q <= inside_d;
    dxs_q <= dxs_d;
    dys_q <= dys_d;
    qx0_q <= qx0_d;
    qx1_q <= qx1_d;
    qy0_q <= qy0_d;
    qy1_q <= qy1_d;
    w_q   <= w_d;
    h_q   <= h_d;
  end

  // Stage 2: exact products. Horizontal edges share the segment dy times the
  // box width, vertical edges the segment dx times the box height.
  logic                 v2_q, in2_q;
  logic signed [PW-1:0] dyw_q, dxh_q, qy0w_q, qy1w_q, qx0h_q, qx1h_q;
  logic signed [PW-1:0] ax0_q, ax1_q, ay0_q, ay1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    in2_q  <= in1_q;
    dyw_q  <= dys_q * w_q;
    dxh_q  <= dxs_q * h_q;
    qy0w_q <= qy0_q * w_q;
    qy1w_q <= qy1_q * w_q;
    qx0h_q <= qx0_q * h_q;
    qx1h_q <= qx1_q * h_q;
    ax0_q  <= qx0_q * dys_q;
    ax1_q  <= qx1_q * dys_q;
    ay0_q  <= qy0_q * dxs_q;
    ay1_q  <= qy1_q * dxs_q;
  end

  // Stage 3: edge parameter t test and numerators of u. Bottom and left
  // edges have denominator and t numerator both negated, which leaves the
  // ratio as is; their u numerator is negated to match.
  logic [3:0]           t_ok_d;
  logic signed [NW-1:0] nub_d, nur_d, nut_d, nul_d;

  always_comb begin
    t_ok_d[0] = unit_ratio(NW'(qy0w_q), NW'(dyw_q));  // bottom
    t_ok_d[1] = unit_ratio(NW'(qx1h_q), NW'(dxh_q));  // right
    t_ok_d[2] = unit_ratio(NW'(qy1w_q), NW'(dyw_q));  // top
    t_ok_d[3] = unit_ratio(NW'(qx0h_q), NW'(dxh_q));  // left
    nub_d = NW'(ay0_q) - NW'(ax0_q);
    nur_d = NW'(ax1_q) - NW'(ay0_q);
    nut_d = NW'(ax1_q) - NW'(ay1_q);
    nul_d = NW'(ay1_q) - NW'(ax0_q);
  end

  logic                 v3_q, in3_q;
  logic [3:0]           t_ok_q;
  logic signed [NW-1:0] nub_q, nur_q, nut_q, nul_q;
  logic signed [PW-1:0] dyw3_q, dxh3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    in3_q  <= in2_q;
    t_ok_q <= t_ok_d;
    nub_q  <= nub_d;
    nur_q  <= nur_d;
    nut_q  <= nut_d;
    nul_q  <= nul_d;
    dyw3_q <= dyw_q;
    dxh3_q <= dxh_q;
  end

  // Stage 4: edge parameter u test and the final decision.
  logic [3:0] u_ok;
  logic       hit_d;

  always_comb begin
    u_ok[0] = unit_ratio(nub_q, NW'(dyw3_q));
    u_ok[1] = unit_ratio(nur_q, NW'(dxh3_q));
    u_ok[2] = unit_ratio(nut_q, NW'(dyw3_q));
    u_ok[3] = unit_ratio(nul_q, NW'(dxh3_q));
    hit_d   = v3_q && (in3_q || |(t_ok_q & u_ok));
  end

  logic valid_q, hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      valid_q <= v3_q;
      hit_q   <= hit_d;
    end
  end

  assign valid_o = valid_q;
  assign hit_o   = hit_q;

endmodule

[rtl/core/sbht_checker.sv]
module sbht_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic valid_o,
  input logic hit_o,
  input logic cfg_valid_i,
  input logic cfg_ready_o
);
  import sbht_pkg::*;

  // Every accepted item yields its result a fixed number of cycles later.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##PIPE_LATENCY valid_o)
    else $error("accepted item gave no result at the expected latency");

  // No result appears without an item accepted the matching number of cycles before.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |-> ##PIPE_LATENCY !valid_o)
    else $error("result strobe without an accepted item");

  // The hit flag is only raised together with its strobe.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> !hit_o)
    else $error("hit raised outside a result cycle");

  // A configuration write is never refused.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write not taken");

endmodule

bind segment_box_hit_test sbht_checker u_sbht_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .valid_o     (valid_o),
  .hit_o       (hit_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);

[verif/tb.sv]
module tb;
  import sbht_pkg::*;

  localparam int CLK_PERIOD = 20;
  localparam int RESET_CYCLES = 11;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int CW = COORD_WIDTH_DEF;
  localparam int RANDOM_PHASES = 6;
  localparam int SEGMENTS_PER_PHASE = 75;
  localparam int C_MIN = 32'sh8000_0000;
  localparam int C_MAX = 32'sh7fff_ffff;

  // Exact arithmetic for products of 33-bit differences and their sums.
  typedef logic signed [71:0] wide_t;

  typedef struct packed {
    logic [FIELD_WIDTH-1:0] start_x;
    logic [FIELD_WIDTH-1:0] start_y;
    logic [FIELD_WIDTH-1:0] end_x;
    logic [FIELD_WIDTH-1:0] end_y;
  } segment_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic [FIELD_WIDTH-1:0]     start_x_i = '0;
  logic [FIELD_WIDTH-1:0]     start_y_i = '0;
  logic [FIELD_WIDTH-1:0]     end_x_i = '0;
  logic [FIELD_WIDTH-1:0]     end_y_i = '0;
  logic                       valid_o;
  logic                       hit_o;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index_i = '0;
  logic [FIELD_WIDTH-1:0]     cfg_data_i = '0;

  // Shadow copy of the box registers, indexed by register index.
  logic [FIELD_WIDTH-1:0] box_reg [0:3] = '{default: '0};

  segment_t segment_backlog [$];
  logic     hit_expected [$];
  segment_t issued_seg;
  int       burst_left;
  int       gap_left;
  int       mismatch_count = 0;

  segment_box_hit_test i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .valid_o     (valid_o),
    .hit_o       (hit_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Append one segment to the end of the backlog.
  function automatic void append_segment(input segment_t seg);
    segment_backlog.insert(segment_backlog.size(), seg);
  endfunction

  // Append one expected hit flag to the end of the scoreboard.
  function automatic void append_expected(input logic hit);
    hit_expected.insert(hit_expected.size(), hit);
  endfunction

  // Sign-extend the low CW bits of a field to the exact working width.
  function automatic wide_t coord_of(input logic [FIELD_WIDTH-1:0] raw);
    logic signed [FIELD_WIDTH-1:0] aligned;
    wide_t coord;
    aligned = raw << (FIELD_WIDTH - CW);
    aligned = aligned >>> (FIELD_WIDTH - CW);
    coord = wide_t'(aligned);
    return coord;
  endfunction

  function automatic logic in_box(input wide_t x, y, lx, hx, ly, hy);
    return x >= lx && x <= hx && y >= ly && y <= hy;
  endfunction

  // True when num/den lies in [0,1]; den is nonzero.
  function automatic logic within_unit(input wide_t num, den);
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    return num >= 0 && num <= den;
  endfunction

  // Segment (x0,y0)-(x1,y1) against box edge (ax,ay)-(bx,by).
  // Parallel lines give a zero denominator and never count as a crossing.
  function automatic logic crosses_edge(input wide_t x0, y0, x1, y1, ax, ay, bx, by);
    wide_t dxs, dys, dxe, dye, qx, qy, den;
    dxs = x1 - x0;
    dys = y1 - y0;
    dxe = bx - ax;
    dye = by - ay;
    qx = ax - x0;
    qy = ay - y0;
    den = dxs * dye - dys * dxe;
    if (den == 0) return 1'b0;
    return within_unit(qx * dye - qy * dxe, den) && within_unit(qx * dys - qy * dxs, den);
  endfunction

  // Expected hit flag for one segment against the current box.
  function automatic logic segment_hits_box(input segment_t seg);
    wide_t x0, y0, x1, y1, lx, hx, ly, hy;
    x0 = coord_of(seg.start_x);
    y0 = coord_of(seg.start_y);
    x1 = coord_of(seg.end_x);
    y1 = coord_of(seg.end_y);
    lx = coord_of(box_reg[REG_BOX_MIN_X]);
    hx = coord_of(box_reg[REG_BOX_MAX_X]);
    ly = coord_of(box_reg[REG_BOX_MIN_Y]);
    hy = coord_of(box_reg[REG_BOX_MAX_Y]);
    return in_box(x0, y0, lx, hx, ly, hy) || in_box(x1, y1, lx, hx, ly, hy)
        || crosses_edge(x0, y0, x1, y1, lx, ly, hx, ly)
        || crosses_edge(x0, y0, x1, y1, hx, ly, hx, hy)
        || crosses_edge(x0, y0, x1, y1, hx, hy, lx, hy)
        || crosses_edge(x0, y0, x1, y1, lx, hy, lx, ly);
  endfunction

  function automatic logic [FIELD_WIDTH-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0: return C_MIN;
      1: return C_MAX;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  // A value in the span between a and b, widened by half the span plus four on each side.
  function automatic logic [FIELD_WIDTH-1:0] pick_near(input logic [FIELD_WIDTH-1:0] a, b);
    longint lo, hi, margin, offset;
    lo = longint'(signed'(a));
    hi = longint'(signed'(b));
    if (lo > hi) begin
      offset = lo;
      lo = hi;
      hi = offset;
    end
    margin = (hi - lo) / 2 + 4;
    offset = longint'({$urandom, $urandom} % (hi - lo + 2 * margin + 1));
    return FIELD_WIDTH'(lo - margin + offset);
  endfunction

  function automatic logic [FIELD_WIDTH-1:0] random_coord(input logic [FIELD_WIDTH-1:0] lo, hi);
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: return pick_extreme();
      3: return $urandom_range(0, 1) ? lo : hi;
      default: return pick_near(lo, hi);
    endcase
  endfunction

  // Mostly segments around the box, with some degenerate and axis-aligned ones.
  function automatic segment_t random_segment();
    segment_t seg;
    seg.start_x = random_coord(box_reg[REG_BOX_MIN_X], box_reg[REG_BOX_MAX_X]);
    seg.start_y = random_coord(box_reg[REG_BOX_MIN_Y], box_reg[REG_BOX_MAX_Y]);
    seg.end_x = random_coord(box_reg[REG_BOX_MIN_X], box_reg[REG_BOX_MAX_X]);
    seg.end_y = random_coord(box_reg[REG_BOX_MIN_Y], box_reg[REG_BOX_MAX_Y]);
    case ($urandom_range(0, 15))
      0: begin
        seg.end_x = seg.start_x;
        seg.end_y = seg.start_y;
      end
      1: seg.end_x = seg.start_x;
      2: seg.end_y = seg.start_y;
      default: ;
    endcase
    return seg;
  endfunction

  task automatic queue_segment(input int sx, sy, ex, ey);
    segment_t seg;
    seg = '{sx, sy, ex, ey};
    append_segment(seg);
  endtask

  // One register write; the shadow copy follows the block's decode.
  task automatic write_box_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                               input logic [FIELD_WIDTH-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_BOX_MIN_X: box_reg[REG_BOX_MIN_X] = data;
      REG_BOX_MAX_X: box_reg[REG_BOX_MAX_X] = data;
      REG_BOX_MIN_Y: box_reg[REG_BOX_MIN_Y] = data;
      REG_BOX_MAX_Y: box_reg[REG_BOX_MAX_Y] = data;
      default: ;
    endcase
  endtask

  task automatic write_unmapped_reg();
    write_box_reg(CFG_INDEX_WIDTH'($urandom_range(int'(REG_BOX_MAX_Y) + 1,
                                                  2 ** CFG_INDEX_WIDTH - 1)), $urandom);
  endtask

  task automatic set_box(input logic [FIELD_WIDTH-1:0] lx, hx, ly, hy);
    write_box_reg(REG_BOX_MIN_X, lx);
    write_box_reg(REG_BOX_MAX_X, hx);
    write_box_reg(REG_BOX_MIN_Y, ly);
    write_box_reg(REG_BOX_MAX_Y, hy);
    if ($urandom_range(0, 2) == 0) write_unmapped_reg();
  endtask

  // Boxes of varied size and position, some inverted, some at the range limits.
  task automatic randomize_box();
    longint cx, cy, hw, hh;
    case ($urandom_range(0, 5))
      0: set_box($urandom, $urandom, $urandom, $urandom);
      1: set_box(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
      default: begin
        cx = longint'(signed'($urandom)) >>> $urandom_range(0, 16);
        cy = longint'(signed'($urandom)) >>> $urandom_range(0, 16);
        hw = longint'($urandom_range(0, 1 << $urandom_range(0, 20)));
        hh = longint'($urandom_range(0, 1 << $urandom_range(0, 20)));
        if ($urandom_range(0, 9) == 0) begin
          set_box(FIELD_WIDTH'(cx + hw), FIELD_WIDTH'(cx - hw),
                  FIELD_WIDTH'(cy + hh), FIELD_WIDTH'(cy - hh));
        end else begin
          set_box(FIELD_WIDTH'(cx - hw), FIELD_WIDTH'(cx + hw),
                  FIELD_WIDTH'(cy - hh), FIELD_WIDTH'(cy + hh));
        end
      end
    endcase
  endtask

  // Wait until every item is issued and answered, then let the pipe settle.
  task automatic drain();
    do @(negedge clk_i);
    while (segment_backlog.size() != 0 || start || hit_expected.size() != 0);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  // Item driver: bursts of random length separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    logic next_start;
    if (!rst_ni) begin
      start <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (start && busy) begin
      // Hold the item until the block takes it.
    end else begin
      if (start) append_expected(segment_hits_box(issued_seg));
      next_start = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (segment_backlog.size() > 0) begin
        issued_seg = segment_backlog.pop_front();
        start_x_i <= issued_seg.start_x;
        start_y_i <= issued_seg.start_y;
        end_x_i <= issued_seg.end_x;
        end_y_i <= issued_seg.end_y;
        next_start = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      start <= next_start;
    end
  end

  // Result monitor: each strobe is checked against the oldest expected hit.
  always @(posedge clk_i) begin
    logic want;
    if (rst_ni && valid_o === 1'b1) begin
      if (hit_expected.size() == 0) begin
        $error("hit: expected none, actual %0b", hit_o);
        mismatch_count++;
      end else begin
        want = hit_expected.pop_front();
        if (hit_o !== want) begin
          $error("hit: expected %0b, actual %0b", want, hit_o);
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus sequence and end of run.
  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset box is a single point at the origin; its edges have zero length.
    queue_segment(0, 0, 0, 0);
    queue_segment(-5, -5, 5, 5);
    queue_segment(0, 0, 7, 7);
    drain();

    // Ordinary box, endpoints inside, crossings, touching and parallel edges.
    set_box(-1000, 1000, -500, 500);
    queue_segment(0, 0, 0, 0);
    queue_segment(5000, 5000, 5000, 5000);
    queue_segment(-2000, 0, 2000, 0);
    queue_segment(-2000, 600, 2000, 600);
    queue_segment(-1000, -500, -3000, -3000);
    queue_segment(-3000, -500, -1001, -500);
    queue_segment(-3000, -500, 3000, -500);
    queue_segment(0, 1500, 2000, -500);
    queue_segment(0, 1502, 2000, -498);
    queue_segment(0, -10000, 0, 10000);
    queue_segment(C_MIN, C_MIN, C_MAX, C_MAX);
    queue_segment(C_MAX, C_MIN, C_MIN, C_MAX);
    queue_segment(C_MIN, C_MIN, C_MIN, C_MAX);
    queue_segment(C_MAX, C_MAX, C_MAX, C_MAX);
    queue_segment(1000, 500, 1000, 500);
    queue_segment(1001, 0, 5000, 0);
    drain();

    // Writes to unmapped indexes must leave the box alone.
    write_box_reg(CFG_INDEX_WIDTH'(REG_BOX_MAX_Y + 1), 32'h7fff_ffff);
    write_box_reg('1, 32'h8000_0000);
    queue_segment(0, 0, 0, 0);
    queue_segment(0, 600, 0, 5000);
    drain();

    // Inverted box: nothing is inside, edges are still tested.
    set_box(1000, -1000, 500, -500);
    queue_segment(0, 0, 0, 0);
    queue_segment(-2000, 0, 2000, 0);
    queue_segment(1000, 500, 1000, 500);
    drain();

    // Box covering the whole range, then a zero-width box on the right limit.
    set_box(C_MIN, C_MAX, C_MIN, C_MAX);
    queue_segment(C_MIN, C_MAX, C_MIN, C_MAX);
    queue_segment(C_MAX, C_MIN, C_MIN, C_MAX);
    drain();
    set_box(C_MAX, C_MAX, C_MIN, C_MAX);
    queue_segment(C_MAX, 0, C_MAX, 0);
    queue_segment(0, 0, C_MAX, 5);
    queue_segment(C_MAX - 1, 0, C_MAX - 1, 5);
    queue_segment(0, C_MIN, C_MAX, C_MAX);
    drain();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      randomize_box();
      for (int n = 0; n < SEGMENTS_PER_PHASE; n++) append_segment(random_segment());
      drain();
    end

    repeat (PIPE_LATENCY * 4) @(posedge clk_i);
    if (hit_expected.size() != 0) begin
      $error("hit: %0d expected results never arrived", hit_expected.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[segment_box_hit_test.f]
rtl/core/sbht_pkg.sv
rtl/core/segment_box_hit_test.sv
rtl/core/sbht_checker.sv
verif/tb.sv
